/* rtl/kli_pkg.sv */
// shared types and constants of the keyframe linear interpolator
// no dependencies; used by the interfaces and by every rtl module but kli_store
`timescale 1ns / 1ps

package kli_pkg;

  localparam int CMD_W  = 2;
  localparam int DUR_W  = 16;
  localparam int FRAC_W = 16;
  localparam int IDX_W  = 4;
  localparam int NCOMP  = 9;
  localparam int STEP_W = $clog2(FRAC_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic t_bit;
  } lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/kli_in_if.sv */
// request channel of the keyframe linear interpolator
// depends on kli_pkg for field widths
`timescale 1ns / 1ps

interface kli_in_if #(
  parameter int COMP_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic [kli_pkg::CMD_W-1:0]     cmd;
  logic [kli_pkg::DUR_W-1:0]     frame_ticks;
  logic signed [COMP_WIDTH-1:0]  rot_x;
  logic signed [COMP_WIDTH-1:0]  rot_y;
  logic signed [COMP_WIDTH-1:0]  rot_z;
  logic signed [COMP_WIDTH-1:0]  scl_x;
  logic signed [COMP_WIDTH-1:0]  scl_y;
  logic signed [COMP_WIDTH-1:0]  scl_z;
  logic signed [COMP_WIDTH-1:0]  pos_x;
  logic signed [COMP_WIDTH-1:0]  pos_y;
  logic signed [COMP_WIDTH-1:0]  pos_z;

  modport source (
    output valid, cmd, frame_ticks, rot_x, rot_y, rot_z,
           scl_x, scl_y, scl_z, pos_x, pos_y, pos_z,
    input  ready
  );

  modport sink (
    input  valid, cmd, frame_ticks, rot_x, rot_y, rot_z,
           scl_x, scl_y, scl_z, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

/* rtl/kli_out_if.sv */
// result channel of the keyframe linear interpolator
// depends on kli_pkg for field widths
`timescale 1ns / 1ps

interface kli_out_if #(
  parameter int COMP_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COMP_WIDTH-1:0]  out_pos_x;
  logic signed [COMP_WIDTH-1:0]  out_pos_y;
  logic signed [COMP_WIDTH-1:0]  out_pos_z;
  logic signed [COMP_WIDTH-1:0]  out_scl_x;
  logic signed [COMP_WIDTH-1:0]  out_scl_y;
  logic signed [COMP_WIDTH-1:0]  out_scl_z;
  logic signed [COMP_WIDTH-1:0]  out_rot_x;
  logic signed [COMP_WIDTH-1:0]  out_rot_y;
  logic signed [COMP_WIDTH-1:0]  out_rot_z;
  logic [kli_pkg::IDX_W-1:0]     frame_index;

  modport source (
    output valid, out_pos_x, out_pos_y, out_pos_z, out_scl_x, out_scl_y,
           out_scl_z, out_rot_x, out_rot_y, out_rot_z, frame_index,
    input  ready
  );

  modport sink (
    input  valid, out_pos_x, out_pos_y, out_pos_z, out_scl_x, out_scl_y,
           out_scl_z, out_rot_x, out_rot_y, out_rot_z, frame_index,
    output ready
  );
endinterface

/* rtl/keyframe_linear_interpolator.sv */
// Looping linear keyframe interpolator. An append request, a clear or an
// ignored request is taken in and completes in the idle state. A tick with a
// non-empty table goes through acceptance, the keyframe store read of the current
// and next keyframe, the bit-serial divider that forms the fraction, the nine
// bit-serial multiply lanes and the load of the output register, in that order.
// Most of a tick is spent in the two one-bit-per-cycle loops. A finished result
// waits in the output register while the next request is already taken in.
`timescale 1ns / 1ps

module keyframe_linear_interpolator #(
  parameter int MAX_FRAMES = 16,
  parameter int COMP_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  kli_in_if.sink     item,
  kli_out_if.source  result
);

  localparam int AW      = $clog2(MAX_FRAMES);
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int ENTRY_W = kli_pkg::DUR_W + kli_pkg::NCOMP * COMP_WIDTH;

  kli_pkg::state_t    state;
  kli_pkg::state_t    state_next;
  kli_pkg::lane_ctl_t lane_ctl;
  kli_pkg::div_stat_t div_st;

  logic [CNT_W-1:0]               frame_count;
  logic [AW-1:0]                  cur;
  logic [AW-1:0]                  nxt;
  logic [kli_pkg::DUR_W-1:0]      tick_count;
  logic [AW-1:0]                  idx_hold;
  logic [kli_pkg::FRAC_W-1:0]     t_sr;
  logic [kli_pkg::STEP_W-1:0]     step_cnt;
  logic [kli_pkg::FRAC_W-1:0]     div_t;
  logic                           out_valid;
  logic                           full;
  logic                           accept;
  logic                           we;
  logic                           re;
  logic                           div_start;
  logic                           out_load;

  logic [kli_pkg::NCOMP-1:0][COMP_WIDTH-1:0] wr_comps;
  logic [kli_pkg::NCOMP-1:0][COMP_WIDTH-1:0] a_comps;
  logic [kli_pkg::NCOMP-1:0][COMP_WIDTH-1:0] b_comps;
  logic [kli_pkg::NCOMP-1:0][COMP_WIDTH-1:0] res;
  logic [kli_pkg::NCOMP-1:0][COMP_WIDTH-1:0] res_q;
  logic [ENTRY_W-1:0]                        wdata;
  logic [ENTRY_W-1:0]                        rd_a;
  logic [ENTRY_W-1:0]                        rd_b;
  logic [kli_pkg::DUR_W-1:0]                 rd_dur;
  logic [kli_pkg::DUR_W:0]                   tick_inc;

  assign accept = item.valid && item.ready;
  assign full   = (frame_count == CNT_W'(MAX_FRAMES));
  assign nxt    = ((CNT_W'(cur) + CNT_W'(1)) == frame_count) ? '0 : AW'(cur + 1'b1);

  // component order: pos x,y,z, scale x,y,z, rot x,y,z
  assign wr_comps[0] = item.pos_x;
  assign wr_comps[1] = item.pos_y;
  assign wr_comps[2] = item.pos_z;
  assign wr_comps[3] = item.scl_x;
  assign wr_comps[4] = item.scl_y;
  assign wr_comps[5] = item.scl_z;
  assign wr_comps[6] = item.rot_x;
  assign wr_comps[7] = item.rot_y;
  assign wr_comps[8] = item.rot_z;
  assign wdata       = {item.frame_ticks, wr_comps};

  kli_store #(
    .DEPTH (MAX_FRAMES),
    .WIDTH (ENTRY_W)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (AW'(frame_count)),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (cur),
    .raddr_b (nxt),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign rd_dur   = rd_a[ENTRY_W-1 -: kli_pkg::DUR_W];
  assign a_comps  = rd_a[kli_pkg::NCOMP*COMP_WIDTH-1:0];
  assign b_comps  = rd_b[kli_pkg::NCOMP*COMP_WIDTH-1:0];
  assign tick_inc = {1'b0, tick_count} + 1'b1;

  kli_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (tick_count),
    .den   (rd_dur),
    .quo   (div_t),
    .stat  (div_st)
  );

  for (genvar j = 0; j < kli_pkg::NCOMP; j++) begin : g_lane
    kli_lerp_lane #(
      .CW (COMP_WIDTH)
    ) u_lane (
      .clk (clk),
      .ctl (lane_ctl),
      .a   (a_comps[j]),
      .b   (b_comps[j]),
      .r   (res[j])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      kli_pkg::S_IDLE: if (re) state_next = kli_pkg::S_LOAD;
      kli_pkg::S_LOAD: state_next = kli_pkg::S_DIV;
      kli_pkg::S_DIV:  if (div_st.done) state_next = kli_pkg::S_MUL;
      kli_pkg::S_MUL: begin
        if (step_cnt == kli_pkg::STEP_W'(kli_pkg::FRAC_W - 1)) begin
          state_next = kli_pkg::S_DONE;
        end
      end
      kli_pkg::S_DONE: if (out_load) state_next = kli_pkg::S_IDLE;
      default:         state_next = kli_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item.ready     = 1'b0;
    we             = 1'b0;
    re             = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    lane_ctl.load  = 1'b0;
    lane_ctl.step  = 1'b0;
    lane_ctl.t_bit = t_sr[0];
    unique case (state)
      kli_pkg::S_IDLE: begin
        item.ready = 1'b1;
        we = item.valid && (item.cmd == kli_pkg::CMD_APPEND) && !full;
        re = item.valid && (item.cmd == kli_pkg::CMD_TICK) && (frame_count != '0);
      end
      kli_pkg::S_LOAD: begin
        div_start     = 1'b1;
        lane_ctl.load = 1'b1;
      end
      kli_pkg::S_DIV: begin
      end
      kli_pkg::S_MUL:  lane_ctl.step = 1'b1;
      kli_pkg::S_DONE: out_load = !out_valid || result.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kli_pkg::S_IDLE;
      frame_count <= '0;
      cur         <= '0;
      tick_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (item.cmd)
          kli_pkg::CMD_APPEND: if (!full) frame_count <= frame_count + 1'b1;
          kli_pkg::CMD_CLEAR: begin
            frame_count <= '0;
            cur         <= '0;
            tick_count  <= '0;
          end
          default: begin
          end
        endcase
      end
      // frame advance, using the duration just read
      if (state == kli_pkg::S_LOAD) begin
        if (tick_inc >= {1'b0, rd_dur}) begin
          tick_count <= '0;
          cur        <= nxt;
        end else begin
          tick_count <= tick_inc[kli_pkg::DUR_W-1:0];
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      idx_hold <= cur;
    end
    if (state == kli_pkg::S_DIV && div_st.done) begin
      t_sr     <= div_t;
      step_cnt <= '0;
    end else if (state == kli_pkg::S_MUL) begin
      t_sr     <= t_sr >> 1;
      step_cnt <= step_cnt + 1'b1;
    end
    if (out_load) begin
      res_q              <= res;
      result.frame_index <= kli_pkg::IDX_W'(idx_hold);
    end
  end

  assign result.valid     = out_valid;
  assign result.out_pos_x = res_q[0];
  assign result.out_pos_y = res_q[1];
  assign result.out_pos_z = res_q[2];
  assign result.out_scl_x = res_q[3];
  assign result.out_scl_y = res_q[4];
  assign result.out_scl_z = res_q[5];
  assign result.out_rot_x = res_q[6];
  assign result.out_rot_y = res_q[7];
  assign result.out_rot_z = res_q[8];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frame_count <= CNT_W'(MAX_FRAMES))
    else $error("keyframe count beyond table depth");

  a_cur_in_table: assert property (@(posedge clk) disable iff (rst)
    (frame_count == '0 && cur == '0) || (CNT_W'(cur) < frame_count))
    else $error("current keyframe outside the filled table");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == kli_pkg::S_DIV)
    else $error("divider finished outside its state");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == kli_pkg::S_IDLE)
    else $error("result not presented after load");

endmodule

/* rtl/kli_store.sv */
// keyframe store: one write port, two registered read ports
// no package dependencies
`timescale 1ns / 1ps

module kli_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/kli_divider.sv */
// bit-serial restoring divider forming the 16-bit frame fraction
// depends on kli_pkg for widths and the status struct
`timescale 1ns / 1ps

module kli_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [kli_pkg::DUR_W-1:0]  num,
  input  logic [kli_pkg::DUR_W-1:0]  den,
  output logic [kli_pkg::FRAC_W-1:0] quo,
  output kli_pkg::div_stat_t         stat
);

  logic [kli_pkg::DUR_W-1:0]  rem;
  logic [kli_pkg::DUR_W-1:0]  den_r;
  logic [kli_pkg::FRAC_W-1:0] q;
  logic                       zero_r;
  logic                       sat_r;
  logic [kli_pkg::STEP_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [kli_pkg::DUR_W:0]    rem2;
  logic [kli_pkg::DUR_W:0]    diff;
  logic                       ge;

  assign rem2 = {rem, 1'b0};
  assign diff = rem2 - {1'b0, den_r};
  assign ge   = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == kli_pkg::STEP_W'(kli_pkg::FRAC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= num;
      den_r  <= den;
      zero_r <= (den == '0);
      sat_r  <= (num >= den);
      q      <= '0;
    end else if (busy) begin
      rem <= ge ? diff[kli_pkg::DUR_W-1:0] : rem2[kli_pkg::DUR_W-1:0];
      q   <= {q[kli_pkg::FRAC_W-2:0], ge};
    end
  end

  // zero duration gives 0, a count at or past the duration saturates
  assign quo = zero_r ? '0 : (sat_r ? '1 : q);

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* rtl/kli_lerp_lane.sv */
// one interpolation lane: a + floor((b - a) * t / 2^16), t taken lsb first
// depends on kli_pkg for the lane control struct
`timescale 1ns / 1ps

module kli_lerp_lane #(
  parameter int CW = 16
) (
  input  logic                      clk,
  input  kli_pkg::lane_ctl_t        ctl,
  input  logic signed [CW-1:0]      a,
  input  logic signed [CW-1:0]      b,
  output logic signed [CW-1:0]      r
);

  logic signed [CW:0]   d;
  logic signed [CW+1:0] acc;
  logic signed [CW+1:0] acc_sum;

  assign acc_sum = acc + (ctl.t_bit ? {d[CW], d} : '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      d   <= {b[CW-1], b} - {a[CW-1], a};
      acc <= '0;
    end else if (ctl.step) begin
      acc <= acc_sum >>> 1;
    end
  end

  // the result lies between a and b, so the low bits carry it exactly
  assign r = a + acc[CW-1:0];

endmodule

/* dv/kli_pose_checker.sv */
// checker for the keyframe linear interpolator: keeps its own keyframe table,
// predicts each interpolated pose and compares it with the result channel
// depends on kli_pkg, kli_in_if and kli_out_if
`timescale 1ns / 1ps

module kli_pose_checker (
  input  logic clk,
  input  logic rst,
  kli_in_if    item,
  kli_out_if   result,
  output int   errors,
  output int   pending
);

  localparam int CW        = 16;
  localparam int KEY_SLOTS = 16;

  // component order: pos x,y,z, scale x,y,z, rot x,y,z
  typedef logic [kli_pkg::NCOMP-1:0][CW-1:0] comps_t;

  typedef struct packed {
    comps_t                    comp;
    logic [kli_pkg::IDX_W-1:0] idx;
  } pose_t;

  logic [kli_pkg::DUR_W-1:0] key_ticks [KEY_SLOTS];
  comps_t                    key_comps [KEY_SLOTS];
  int                        key_count;
  int                        cur_key;
  logic [kli_pkg::DUR_W-1:0] ticks_in_key;
  pose_t                     expected_poses [$];

  string comp_names [kli_pkg::NCOMP] = '{"out_pos_x", "out_pos_y", "out_pos_z",
                                         "out_scl_x", "out_scl_y", "out_scl_z",
                                         "out_rot_x", "out_rot_y", "out_rot_z"};

  task automatic count_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : watch
    pose_t                     seen;
    pose_t                     want;
    pose_t                     pose;
    int                        nxt;
    logic [kli_pkg::DUR_W-1:0] dur;
    longint                    a;
    longint                    b;
    longint                    frac;
    longint                    lerp_val;

    if (rst) begin
      key_count    = 0;
      cur_key      = 0;
      ticks_in_key = '0;
      errors       = 0;
      expected_poses.delete();
    end else begin
      // results first: a result can never come from the request taken this edge
      if (result.valid && result.ready) begin
        seen = {result.out_rot_z, result.out_rot_y, result.out_rot_x,
                result.out_scl_z, result.out_scl_y, result.out_scl_x,
                result.out_pos_z, result.out_pos_y, result.out_pos_x,
                result.frame_index};
        if (expected_poses.size() == 0) begin
          count_error($sformatf("unexpected result, frame_index %0d", seen.idx));
        end else begin
          want = expected_poses.pop_front();
          for (int j = 0; j < kli_pkg::NCOMP; j++) begin
            if (seen.comp[j] !== want.comp[j])
              count_error($sformatf("%s mismatch: expected %0d got %0d", comp_names[j],
                                    $signed(want.comp[j]), $signed(seen.comp[j])));
          end
          if (seen.idx !== want.idx)
            count_error($sformatf("frame_index mismatch: expected %0d got %0d",
                                  want.idx, seen.idx));
        end
      end

      if (item.valid && item.ready) begin
        case (item.cmd)
          kli_pkg::CMD_APPEND: begin
            if (key_count < KEY_SLOTS) begin
              key_ticks[key_count] = item.frame_ticks;
              key_comps[key_count] = {item.rot_z, item.rot_y, item.rot_x,
                                      item.scl_z, item.scl_y, item.scl_x,
                                      item.pos_z, item.pos_y, item.pos_x};
              key_count++;
            end
          end
          kli_pkg::CMD_CLEAR: begin
            key_count    = 0;
            cur_key      = 0;
            ticks_in_key = '0;
          end
          kli_pkg::CMD_TICK: begin
            if (key_count != 0) begin
              nxt = (cur_key + 1) % key_count;
              dur = key_ticks[cur_key];
              if (dur == 0) begin
                frac = 0;
              end else begin
                frac = (longint'(ticks_in_key) << 16) / longint'(dur);
                if (frac > 64'hFFFF) frac = 64'hFFFF;
              end
              for (int j = 0; j < kli_pkg::NCOMP; j++) begin
                a        = $signed(key_comps[cur_key][j]);
                b        = $signed(key_comps[nxt][j]);
                // arithmetic shift gives the floor of the scaled difference
                lerp_val = a + (((b - a) * frac) >>> 16);
                pose.comp[j] = lerp_val[CW-1:0];
              end
              pose.idx = cur_key[kli_pkg::IDX_W-1:0];
              expected_poses.insert(expected_poses.size(), pose);
              if (32'(ticks_in_key) + 1 >= 32'(dur)) begin
                ticks_in_key = '0;
                cur_key      = nxt;
              end else begin
                ticks_in_key = ticks_in_key + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
    pending = expected_poses.size();
  end

endmodule

/* dv/testbench.sv */
// top of the keyframe linear interpolator testbench: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict
// depends on kli_pkg, kli_in_if, kli_out_if, kli_pose_checker and the rtl
`timescale 1ns / 1ps

module testbench;

  localparam int CW         = 16;
  localparam int HOLD_OFF   = 200;
  localparam int IDLE_LIMIT = 2000;
  localparam int ITEM_GOAL  = 500;

  typedef logic [kli_pkg::NCOMP-1:0][CW-1:0] keyframe_t;

  logic clk;
  logic rst;
  int   error_count;
  int   pending_count;
  int   items_sent;
  bit   tx_steady;
  bit   rx_steady;

  kli_in_if  #(.COMP_WIDTH(CW)) item_ch ();
  kli_out_if #(.COMP_WIDTH(CW)) result_ch ();

  keyframe_linear_interpolator #(
    .MAX_FRAMES(16),
    .COMP_WIDTH(CW)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  kli_pose_checker pose_check (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .errors  (error_count),
    .pending (pending_count)
  );

  always #5 clk = ~clk;

  function automatic keyframe_t random_key();
    keyframe_t k;
    for (int j = 0; j < kli_pkg::NCOMP; j++) k[j] = CW'($urandom);
    return k;
  endfunction

  // mostly short keyframes so the animation loops often
  function automatic logic [kli_pkg::DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return kli_pkg::DUR_W'($urandom_range(1, 16'hFFFF));
      1:       return 16'hFFFF;
      default: return kli_pkg::DUR_W'($urandom_range(1, 4));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue_request(input kli_pkg::cmd_t cmd,
                               input logic [kli_pkg::DUR_W-1:0] ticks,
                               input keyframe_t key);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.cmd         <= cmd;
    item_ch.frame_ticks <= ticks;
    item_ch.pos_x       <= key[0];
    item_ch.pos_y       <= key[1];
    item_ch.pos_z       <= key[2];
    item_ch.scl_x       <= key[3];
    item_ch.scl_y       <= key[4];
    item_ch.scl_z       <= key[5];
    item_ch.rot_x       <= key[6];
    item_ch.rot_y       <= key[7];
    item_ch.rot_z       <= key[8];
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int n;
    clk                 = 1'b0;
    rst                 = 1'b1;
    items_sent          = 0;
    tx_steady           = 1'b0;
    item_ch.valid       = 1'b0;
    item_ch.cmd         = kli_pkg::CMD_TICK;
    item_ch.frame_ticks = '0;
    item_ch.pos_x       = '0;
    item_ch.pos_y       = '0;
    item_ch.pos_z       = '0;
    item_ch.scl_x       = '0;
    item_ch.scl_y       = '0;
    item_ch.scl_z       = '0;
    item_ch.rot_x       = '0;
    item_ch.rot_y       = '0;
    item_ch.rot_z       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // tick on an empty table, then swing between the component extremes
    issue_request(kli_pkg::CMD_TICK, 16'd1, random_key());
    issue_request(kli_pkg::CMD_APPEND, 16'd3, {kli_pkg::NCOMP{16'h8000}});
    issue_request(kli_pkg::CMD_APPEND, 16'd1, {kli_pkg::NCOMP{16'h7FFF}});
    repeat (5) issue_request(kli_pkg::CMD_TICK, pick_duration(), random_key());
    issue_request(kli_pkg::CMD_APPEND, 16'hFFFF, random_key());
    repeat (3) issue_request(kli_pkg::CMD_TICK, pick_duration(), random_key());
    issue_request(kli_pkg::CMD_CLEAR, pick_duration(), random_key());
    issue_request(kli_pkg::CMD_TICK, pick_duration(), random_key());
    // single keyframe loops onto itself
    issue_request(kli_pkg::CMD_APPEND, 16'd2, random_key());
    repeat (3) issue_request(kli_pkg::CMD_TICK, pick_duration(), random_key());
    issue_request(kli_pkg::CMD_CLEAR, pick_duration(), random_key());

    while (items_sent < ITEM_GOAL) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0)
        issue_request(kli_pkg::CMD_CLEAR, pick_duration(), random_key());
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 5);
      repeat (n) issue_request(kli_pkg::CMD_APPEND, pick_duration(), random_key());
      repeat ($urandom_range(n, 3 * n + 10)) begin
        case ($urandom_range(0, 19))
          0:       issue_request(kli_pkg::CMD_APPEND, pick_duration(), random_key());
          1:       issue_request(kli_pkg::CMD_CLEAR, pick_duration(), random_key());
          default: issue_request(kli_pkg::CMD_TICK, pick_duration(), random_key());
        endcase
      end
    end
    item_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_sink
    int taken;
    int stall;
    taken           = 0;
    rx_steady       = 1'b0;
    result_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (taken % 16 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, 5);
      // long hold-off so the block fills up and stalls its input
      if (taken == 25 || taken == 200) stall = HOLD_OFF;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
